FILE: hw/rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int DEF_TIMER_SLOTS = 64;
  localparam int DEF_EVENT_SLOTS = 32;

  // field widths
  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int SEC_W    = 32;
  localparam int TGT_W    = 9;
  localparam int CNT_W    = 7;
  localparam int PEND_W   = 32;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  // stream words, padded to whole bytes
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } ptb_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_TIMERS = 1'd0,
    CFG_EVENT_COUNT   = 1'd1
  } ptb_cfg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } ptb_state_e;

  typedef struct packed {
    logic [SEC_W-1:0] remaining;
    logic [SEC_W-1:0] period;
    logic [TGT_W-1:0] target;
  } timer_entry_t;

endpackage

FILE: hw/rtl/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of one-second down-counting timers with reload and event flags.
// ----------------------------------------------------------------------------
// After reset the block sweeps the entry memory once, zeroing one entry per
// cycle, so s_axis_tready_o stays low until every entry is cleared. A tick
// word then sweeps the first min(active_timers, TIMER_SLOTS) entries before
// the input is free again. Every swept entry is read from the entry memory;
// a nonzero one is then decremented or reloaded and written back in the
// cycle after its read, one entry per cycle. A load, a flag clear or an
// unused mode goes straight from idle to the done state. The result word
// sits in an output register, so the next word is taken while a result still
// waits to be read. A finished word whose result cannot yet move to that
// register holds the block until the register is read.
module periodic_timer_bank #(
  parameter int TIMER_SLOTS = ptb_pkg::DEF_TIMER_SLOTS,
  parameter int EVENT_SLOTS = ptb_pkg::DEF_EVENT_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptb_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input words
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // mode, slot, start_seconds, period_seconds, target_event, zero pad
  input  logic [ptb_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // result words
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // expired_count, bad_target_count, pending_events, zero pad
  output logic [ptb_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import ptb_pkg::*;

  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int SW = AW + 1;
  localparam int EW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

  // input fields
  ptb_mode_e          in_mode;
  logic [SLOT_W-1:0]  in_slot;
  timer_entry_t       in_entry;

  assign in_mode            = ptb_mode_e'(s_axis_tdata_i[1:0]);
  assign in_slot            = s_axis_tdata_i[7:2];
  assign in_entry.remaining = s_axis_tdata_i[39:8];
  assign in_entry.period    = s_axis_tdata_i[71:40];
  assign in_entry.target    = s_axis_tdata_i[80:72];

  // configuration
  logic [CFG_W-1:0] act_q;
  logic [5:0]       evc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      evc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (ptb_cfg_e'(cfg_idx_i))
        CFG_ACTIVE_TIMERS: act_q <= cfg_wdata_i;
        CFG_EVENT_COUNT:   evc_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] sweep_len;

  always_comb begin
    if (32'(act_q) > 32'(TIMER_SLOTS)) begin
      sweep_len = SW'(TIMER_SLOTS);
    end else begin
      sweep_len = SW'(act_q);
    end
  end

  // entry memory
  timer_entry_t timer_mem [TIMER_SLOTS];
  timer_entry_t rd_data_q;
  logic         rd_en;
  logic [AW-1:0] rd_addr;
  logic         mem_we;
  logic [AW-1:0] mem_waddr;
  timer_entry_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      timer_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= timer_mem[rd_addr];
    end
  end

  // control state
  ptb_state_e           state_q, state_d;
  logic [SW-1:0]        idx_q, idx_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [AW-1:0]        proc_addr_q;
  logic [CNT_W-1:0]     cnt_exp_q, cnt_exp_d;
  logic [CNT_W-1:0]     cnt_bad_q, cnt_bad_d;
  logic [EVENT_SLOTS-1:0] flags_q, flags_d;
  logic                 push;

  // output register
  logic                 out_vld_q;
  logic [CNT_W-1:0]     out_exp_q;
  logic [CNT_W-1:0]     out_bad_q;
  logic [PEND_W-1:0]    out_pend_q;
  logic [63:0]          flags_ext;

  assign flags_ext = 64'(flags_q);

  // expiry decode of the entry read last cycle
  logic [SEC_W-1:0] rem_dec;
  logic             tgt_ok;

  assign rem_dec = rd_data_q.remaining - 1'b1;
  assign tgt_ok  = !rd_data_q.target[TGT_W-1]
                && (32'(rd_data_q.target[TGT_W-2:0]) < 32'(evc_q))
                && (32'(rd_data_q.target[TGT_W-2:0]) < 32'(EVENT_SLOTS));

  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    rd_vld_d        = 1'b0;
    cnt_exp_d       = cnt_exp_q;
    cnt_bad_d       = cnt_bad_q;
    flags_d         = flags_q;
    mem_we          = 1'b0;
    mem_waddr       = proc_addr_q;
    mem_wdata       = rd_data_q;
    rd_en           = 1'b0;
    rd_addr         = idx_q[AW-1:0];
    push            = 1'b0;
    s_axis_tready_o = 1'b0;

    // write-back stage of the sweep
    if (rd_vld_q && (rd_data_q.remaining != '0)) begin
      mem_we = 1'b1;
      if (rem_dec == '0) begin
        mem_wdata.remaining = rd_data_q.period;
        cnt_exp_d = cnt_exp_q + 1'b1;
        if (tgt_ok) begin
          flags_d[rd_data_q.target[EW-1:0]] = 1'b1;
        end else begin
          cnt_bad_d = cnt_bad_q + 1'b1;
        end
      end else begin
        mem_wdata.remaining = rem_dec;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = '0;
        if (idx_q == SW'(TIMER_SLOTS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cnt_exp_d = '0;
          cnt_bad_d = '0;
          state_d   = ST_DONE;
          unique case (in_mode)
            MODE_TICK: begin
              idx_d   = '0;
              state_d = ST_SWEEP;
            end
            MODE_LOAD: begin
              if (32'(in_slot) < 32'(TIMER_SLOTS)) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_slot);
                mem_wdata = in_entry;
              end
            end
            MODE_CLEAR: begin
              if (32'(in_slot) < 32'(EVENT_SLOTS)) begin
                flags_d[in_slot[EW-1:0]] = 1'b0;
              end
            end
            MODE_NONE: ;
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        if (idx_q < sweep_len) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          idx_d    = idx_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      cnt_exp_q <= '0;
      cnt_bad_q <= '0;
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_vld_q  <= rd_vld_d;
      cnt_exp_q <= cnt_exp_d;
      cnt_bad_q <= cnt_bad_d;
      flags_q   <= flags_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      proc_addr_q <= rd_addr;
    end
    if (push) begin
      out_exp_q  <= cnt_exp_q;
      out_bad_q  <= cnt_bad_q;
      out_pend_q <= flags_ext[PEND_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_pend_q, out_bad_q, out_exp_q};

  // the sweep never reads the entry it is writing back
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (mem_waddr != rd_addr))
    else $error("entry memory read and write hit the same entry");

  a_bad_le_expired : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_bad_q <= cnt_exp_q)
    else $error("bad target count exceeds expiry count");

  a_idle_pipe_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !rd_vld_q)
    else $error("sweep stage busy while idle");

  a_push_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_vld_q)
    else $error("finished result not presented");

endmodule
